@@ src/spimrb_pkg.sv @@
// shared widths, codes and register offsets of the spi master register block
`default_nettype none

package spimrb_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned STATUS_W = 17;
    localparam int unsigned RX_W     = 20;
    localparam int unsigned NUM_CS   = 4;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RX_UNIT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MODF    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_OVRES   = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OFFSET    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CS        = 2'd2;
    localparam logic [ERR_W-1:0] ERR_WIDTH     = 2'd3;

    // register offsets
    localparam logic [OFFSET_W-1:0] OFF_CR  = 6'h00;
    localparam logic [OFFSET_W-1:0] OFF_MR  = 6'h04;
    localparam logic [OFFSET_W-1:0] OFF_RDR = 6'h08;
    localparam logic [OFFSET_W-1:0] OFF_TDR = 6'h0C;
    localparam logic [OFFSET_W-1:0] OFF_SR  = 6'h10;
    localparam logic [OFFSET_W-1:0] OFF_IER = 6'h14;
    localparam logic [OFFSET_W-1:0] OFF_IDR = 6'h18;
    localparam logic [OFFSET_W-1:0] OFF_IMR = 6'h1C;

    // status bits
    localparam int unsigned ST_RDRF    = 0;
    localparam int unsigned ST_TDRE    = 1;
    localparam int unsigned ST_MODF    = 2;
    localparam int unsigned ST_OVRES   = 3;
    localparam int unsigned ST_NSSR    = 8;
    localparam int unsigned ST_TXEMPTY = 9;
    localparam int unsigned ST_SPIENS  = 16;
    localparam int unsigned IRQ_BITS   = 10;

    localparam logic [STATUS_W-1:0] STATUS_RESET = 17'h000F0;
    localparam logic [STATUS_W-1:0] STATUS_SWRST = 17'h000C0;
    localparam logic [STATUS_W-1:0] STATUS_KEEP  = 17'h00030;

    // mode bits
    localparam int unsigned MD_MSTR   = 0;
    localparam int unsigned MD_PS     = 1;
    localparam int unsigned MD_PCSDEC = 2;

    // control bits
    localparam int unsigned CR_EN       = 0;
    localparam int unsigned CR_DIS      = 1;
    localparam int unsigned CR_SOFT_RST = 7;

endpackage

`default_nettype wire

@@ src/spimrb_if.sv @@
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface spimrb_req_if;
    import spimrb_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   wdata;
    logic [WORD_W-1:0]   rx_unit;

    modport source (output valid, func, offset, wdata, rx_unit, input ready);
    modport sink   (input valid, func, offset, wdata, rx_unit, output ready);
endinterface

interface spimrb_rsp_if;
    import spimrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] rdata;
    logic              irq;
    logic              tx_valid;
    logic [WORD_W-1:0] tx_unit;
    logic [ERR_W-1:0]  error;

    modport source (output valid, rdata, irq, tx_valid, tx_unit, error, input ready);
    modport sink   (input valid, rdata, irq, tx_valid, tx_unit, error, output ready);
endinterface

`default_nettype wire

@@ src/spi_master_register_block.sv @@
// spi master register block: bus registers, chip select choice, transfer and loopback
//
//  channel   dir  beat contents
//  i_req     in   func, offset, wdata, rx_unit
//  o_rsp     out  rdata, irq, tx_valid, tx_unit, error
//  i_cfg_*   in   partner_connected (write only)
//
// one beat per cycle while i_req.ready is high: each request is decoded and
// applied to the register file in the cycle it is taken, its result lands in
// the output register. i_req.ready drops only while the output register is
// full and not taken. synchronous active-low reset returns the state registers
// and r_out_valid to their power-up values; the output data registers are not reset.
`default_nettype none

module spi_master_register_block (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spimrb_req_if.sink   i_req,
    spimrb_rsp_if.source o_rsp,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);
    import spimrb_pkg::*;

    logic                r_partner;
    logic [WORD_W-1:0]   r_mode,   n_mode;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [WORD_W-1:0]   r_mask,   n_mask;
    logic [RX_W-1:0]     r_rx,     n_rx;
    logic [WORD_W-1:0]   r_tx,     n_tx;
    logic [WORD_W-1:0]   r_csr [NUM_CS];
    logic [WORD_W-1:0]   n_csr [NUM_CS];
    logic                r_await,  n_await;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_rdata,  n_rdata;
    logic                r_irq,    n_irq;
    logic                r_txv,    n_txv;
    logic [WORD_W-1:0]   r_txu,    n_txu;
    logic [ERR_W-1:0]    r_err,    n_err;

    logic accept;

    // transmit path
    logic [3:0]  tx_pcs;
    logic [3:0]  tx_nr;
    logic        tx_pcs_ok;
    logic [3:0]  tx_field;
    logic [WORD_W-1:0] tx_unit;

    // shared receive path, fed by a partner unit or a looped-back one
    logic [WORD_W-1:0] tk_unit;
    logic [3:0]  tk_nr;
    logic [3:0]  tk_field;
    logic        tk_bad;
    logic [RX_W-1:0] tk_rx;

    logic csr_off;

    function automatic logic [15:0] keep_low(input logic [15:0] data, input logic [3:0] field);
        logic [15:0] res;
        for (int i = 0; i < 16; i++) begin
            res[i] = data[i] & ((5'(i) < (5'(field) + 5'd8)) ? 1'b1 : 1'b0);
        end
        return res;
    endfunction

    function automatic logic [3:0] cs_code(input logic [WORD_W-1:0] mode, input logic [3:0] nr);
        logic [3:0] code;
        if (!mode[MD_MSTR]) begin
            code = 4'd0;
        end else if (mode[MD_PCSDEC]) begin
            code = nr;
        end else begin
            code = ~(4'd1 << nr[3:2]);
        end
        return code;
    endfunction

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign csr_off     = (i_req.offset[5:4] == 2'b11) && (i_req.offset[1:0] == 2'b00);

    always_comb begin
        tx_pcs = r_mode[MD_PS] ? i_req.wdata[19:16] : r_mode[19:16];
        tx_pcs_ok = 1'b1;
        if (r_mode[MD_PCSDEC]) begin
            tx_nr = tx_pcs;
        end else if (!tx_pcs[0]) begin
            tx_nr = 4'd0;
        end else if (!tx_pcs[1]) begin
            tx_nr = 4'd4;
        end else if (!tx_pcs[2]) begin
            tx_nr = 4'd8;
        end else if (!tx_pcs[3]) begin
            tx_nr = 4'd12;
        end else begin
            tx_nr = 4'd0;
            tx_pcs_ok = 1'b0;
        end
        tx_field = r_csr[tx_nr[3:2]][7:4];
        tx_unit  = {4'd0, tx_nr, 4'd0, tx_field, keep_low(i_req.wdata[15:0], tx_field)};
    end

    always_comb begin
        tk_unit  = (i_req.func == FUNC_WRITE) ? tx_unit : i_req.rx_unit;
        tk_nr    = tk_unit[27:24];
        tk_field = r_csr[tk_nr[3:2]][7:4];
        tk_bad   = (tk_field > 4'd8) || (tk_unit[23:16] != {4'd0, tk_field});
        tk_rx    = {cs_code(r_mode, tk_nr), keep_low(tk_unit[15:0], tk_field)};
    end

    always_comb begin
        logic do_take;
        do_take  = 1'b0;
        n_mode   = r_mode;
        n_status = r_status;
        n_mask   = r_mask;
        n_rx     = r_rx;
        n_tx     = r_tx;
        n_csr    = r_csr;
        n_await  = r_await;
        n_rdata  = '0;
        n_txv    = 1'b0;
        n_txu    = '0;
        n_err    = ERR_OK;

        case (i_req.func)
            FUNC_READ: begin
                if (i_req.offset == OFF_MR) begin
                    n_rdata = r_mode;
                end else if (i_req.offset == OFF_RDR) begin
                    n_rdata = {12'd0, r_rx};
                    n_status[ST_RDRF] = 1'b0;
                end else if (i_req.offset == OFF_SR) begin
                    n_rdata = {15'd0, r_status};
                    n_status[ST_MODF]  = 1'b0;
                    n_status[ST_OVRES] = 1'b0;
                    n_status[ST_NSSR]  = 1'b0;
                end else if (i_req.offset == OFF_IMR) begin
                    n_rdata = r_mask;
                end else if (csr_off) begin
                    n_rdata = r_csr[i_req.offset[3:2]];
                end else begin
                    n_err = ERR_OFFSET;
                end
            end
            FUNC_WRITE: begin
                if (i_req.offset == OFF_CR) begin
                    if (i_req.wdata[CR_EN] && !i_req.wdata[CR_DIS]) begin
                        n_status[ST_SPIENS]  = 1'b1;
                        n_status[ST_TDRE]    = 1'b1;
                        n_status[ST_TXEMPTY] = 1'b1;
                    end
                    if (i_req.wdata[CR_DIS]) begin
                        n_status[ST_SPIENS]  = 1'b0;
                        n_status[ST_TDRE]    = 1'b0;
                        n_status[ST_TXEMPTY] = 1'b0;
                    end
                    if (i_req.wdata[CR_SOFT_RST]) begin
                        n_mode   = '0;
                        n_rx     = '0;
                        n_tx     = '0;
                        n_mask   = '0;
                        for (int i = 0; i < NUM_CS; i++) begin
                            n_csr[i] = '0;
                        end
                        n_status = STATUS_SWRST | (r_status & STATUS_KEEP);
                    end
                end else if (i_req.offset == OFF_MR) begin
                    n_mode = i_req.wdata;
                end else if (i_req.offset == OFF_TDR) begin
                    n_tx = i_req.wdata;
                    if (!r_mode[MD_MSTR]) begin
                        // slave mode: only the flags move
                        n_status[ST_TDRE]    = 1'b0;
                        n_status[ST_TXEMPTY] = 1'b0;
                    end else if (!tx_pcs_ok) begin
                        n_err = ERR_CS;
                    end else if (tx_field > 4'd8) begin
                        n_err = ERR_WIDTH;
                    end else begin
                        n_await = 1'b1;
                        if (r_partner) begin
                            n_txv = 1'b1;
                            n_txu = tx_unit;
                        end else begin
                            do_take = 1'b1;
                        end
                    end
                end else if (i_req.offset == OFF_IER) begin
                    n_mask = r_mask | i_req.wdata;
                end else if (i_req.offset == OFF_IDR) begin
                    n_mask = r_mask & ~i_req.wdata;
                end else if (csr_off) begin
                    n_csr[i_req.offset[3:2]] = i_req.wdata;
                end else begin
                    n_err = ERR_OFFSET;
                end
            end
            FUNC_RX_UNIT: begin
                if (r_await) begin
                    if (tk_bad) begin
                        n_err = ERR_WIDTH;
                    end else begin
                        do_take = 1'b1;
                    end
                end
            end
            FUNC_MODF: begin
                n_status[ST_MODF] = 1'b1;
            end
            FUNC_OVRES: begin
                n_status[ST_OVRES] = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_take) begin
            // overrun when the previous unit was never read
            if (r_status[ST_RDRF]) begin
                n_status[ST_OVRES] = 1'b1;
            end
            n_rx = tk_rx;
            n_status[ST_RDRF]    = 1'b1;
            n_status[ST_TDRE]    = 1'b1;
            n_status[ST_TXEMPTY] = 1'b1;
            n_await = 1'b0;
        end

        n_irq = |(n_status[IRQ_BITS-1:0] & n_mask[IRQ_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partner <= 1'b0;
        end else if (i_cfg_we) begin
            r_partner <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_status <= STATUS_RESET;
            r_mask   <= '0;
            r_rx     <= '0;
            r_tx     <= '0;
            for (int i = 0; i < NUM_CS; i++) begin
                r_csr[i] <= '0;
            end
            r_await  <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_status <= n_status;
            r_mask   <= n_mask;
            r_rx     <= n_rx;
            r_tx     <= n_tx;
            r_csr    <= n_csr;
            r_await  <= n_await;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= n_rdata;
            r_irq   <= n_irq;
            r_txv   <= n_txv;
            r_txu   <= n_txu;
            r_err   <= n_err;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.rdata    = r_rdata;
    assign o_rsp.irq      = r_irq;
    assign o_rsp.tx_valid = r_txv;
    assign o_rsp.tx_unit  = r_txu;
    assign o_rsp.error    = r_err;

    // a unit only leaves with a clean result
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.tx_valid) |-> (o_rsp.error == ERR_OK))
        else $error("tx unit with error code");

    // loopback mode never sends to the partner
    a_loopback_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_partner) |=> !o_rsp.tx_valid)
        else $error("tx unit sent without partner");

    // reading receive data clears rdrf
    a_rdr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.func == FUNC_READ) && (i_req.offset == OFF_RDR))
        |=> !r_status[ST_RDRF])
        else $error("rdrf still set after rdr read");

    // a sent unit leaves the block waiting for a reply
    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_txv) |=> r_await)
        else $error("not awaiting after send");

    // status bits above the interrupt range besides spiens stay clear
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[ST_SPIENS-1:IRQ_BITS] == '0)
        else $error("unused status bits set");

endmodule

`default_nettype wire
